>>> hdl/hssc_pkg.sv
// ----------------------------------------------------------------------------
// hssc_pkg
// Types and constants shared by the hall six-step commutator modules.
// ----------------------------------------------------------------------------
package hssc_pkg;

	// PWM period in nanoseconds and field widths
	localparam int unsigned PERIOD_NS  = 50000;
	localparam int unsigned HALL_W     = 3;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned DUTY_W     = 10;
	localparam int unsigned PULSE_W    = 16;
	localparam int unsigned STREAK_W   = 8;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DUTY      = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_DUTY_LIM  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_REVERSE   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_GAP   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_GAP   = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_LIM   = 3'd6;

	// hall codes that mean nothing
	localparam logic [HALL_W-1:0] HALL_ALL_LOW  = 3'd0;
	localparam logic [HALL_W-1:0] HALL_ALL_HIGH = 3'd7;

	localparam logic [1:0] NO_PHASE = 2'd3;
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_FWD  = 2'b01;
	localparam logic [1:0] DIR_REV  = 2'b11;

	// phase tables indexed by hall code
	localparam logic [1:0] FWD_HI [8] = '{2'd3, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};
	localparam logic [1:0] FWD_LO [8] = '{2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd3};
	// position of each valid code on the ring 1,5,4,6,2,3
	localparam logic [2:0] RING_POS [8] = '{3'd0, 3'd0, 3'd4, 3'd5, 3'd2, 3'd1, 3'd3, 3'd0};

	// pulse = (duty * PERIOD_NS + 500) / 1000 via reciprocal multiply
	localparam int unsigned SCALED_W    = $clog2(((2 ** DUTY_W) - 1) * PERIOD_NS + 501);
	localparam int unsigned RECIP_SHIFT = SCALED_W + 10;
	localparam int unsigned RECIP_W     = RECIP_SHIFT - 9;
	localparam int unsigned QUOT_W      = SCALED_W - 9;
	localparam logic [63:0] RECIP_MUL   = ((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000;
	localparam logic [SCALED_W-1:0] ROUND_HALF = SCALED_W'(500);
	localparam logic [SCALED_W-1:0] PERIOD_SC  = SCALED_W'(PERIOD_NS);
	localparam logic [QUOT_W-1:0]   PERIOD_Q   = QUOT_W'(PERIOD_NS);

	// max_gap / 8000 = (max_gap >> 6) / 125, the /125 by reciprocal
	localparam int unsigned GAP_PRE_SHIFT = 6;
	localparam int unsigned GAP_IN_W      = TIME_W - GAP_PRE_SHIFT;
	localparam int unsigned GAP_SHIFT     = GAP_IN_W + 7;
	localparam int unsigned GAP_MUL_W     = GAP_SHIFT - 6;
	localparam int unsigned GAP_Q_W       = GAP_IN_W - 6;
	localparam logic [63:0] GAP_MUL       = ((64'd1 << GAP_SHIFT) + 64'd124) / 64'd125;

	typedef struct packed {
		logic                enable;
		logic [DUTY_W-1:0]   duty;
		logic [DUTY_W-1:0]   duty_limit;
		logic                reverse;
		logic [TIME_W-1:0]   max_gap;
		logic [TIME_W-1:0]   min_eff;   // min gap with the zero case resolved
		logic [STREAK_W-1:0] inv_limit;
	} cfg_t;

	typedef struct packed {
		logic                drive_on;
		logic [1:0]          high_phase;
		logic [1:0]          low_phase;
		logic [SCALED_W-1:0] scaled;
		logic                is_running;
		logic [31:0]         transition_total;
		logic [31:0]         edge_period;
		logic [1:0]          edge_direction;
	} stage_t;

	typedef struct packed {
		logic [1:0]         high_phase;
		logic [1:0]         low_phase;
		logic [PULSE_W-1:0] pulse_width;
		logic [2:0]         phase_enable;
		logic               is_running;
		logic [31:0]        transition_total;
		logic [31:0]        edge_period;
		logic [1:0]         edge_direction;
	} result_t;

endpackage

>>> hdl/hssc_cfg.sv
// ----------------------------------------------------------------------------
// hssc_cfg
// Configuration registers; resolves the effective minimum edge gap on write.
// ----------------------------------------------------------------------------
module hssc_cfg import hssc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_ADDR_W-1:0] addr,
	input  logic [CFG_DATA_W-1:0] wdata,
	output cfg_t                  cfg
);

	logic                enable_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [DUTY_W-1:0]   duty_lim_q;
	logic                reverse_q;
	logic [TIME_W-1:0]   min_gap_q;
	logic [TIME_W-1:0]   max_gap_q;
	logic [STREAK_W-1:0] inv_lim_q;
	logic [TIME_W-1:0]   min_eff_q;

	logic [TIME_W-1:0]             next_min;
	logic [TIME_W-1:0]             next_max;
	logic [GAP_IN_W+GAP_MUL_W-1:0] gap_prod;
	logic [TIME_W-1:0]             next_min_eff;

	// zero min gap means max gap / 8000; worked out from the value being written
	always_comb begin
		next_min = (we && addr == REG_MIN_GAP) ? wdata[TIME_W-1:0] : min_gap_q;
		next_max = (we && addr == REG_MAX_GAP) ? wdata[TIME_W-1:0] : max_gap_q;
		gap_prod = (GAP_IN_W+GAP_MUL_W)'(next_max[TIME_W-1:GAP_PRE_SHIFT])
			* (GAP_IN_W+GAP_MUL_W)'(GAP_MUL[GAP_MUL_W-1:0]);
		if (next_min != '0) begin
			next_min_eff = next_min;
		end else begin
			next_min_eff = TIME_W'(gap_prod[GAP_SHIFT +: GAP_Q_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			duty_q     <= '0;
			duty_lim_q <= DUTY_W'(950);
			reverse_q  <= 1'b0;
			min_gap_q  <= TIME_W'(3600);
			max_gap_q  <= TIME_W'(48000000);
			inv_lim_q  <= STREAK_W'(8);
			min_eff_q  <= TIME_W'(3600);
		end else begin
			min_eff_q <= next_min_eff;
			if (we) begin
				unique case (addr)
					REG_ENABLE:   enable_q   <= wdata[0];
					REG_DUTY:     duty_q     <= wdata[DUTY_W-1:0];
					REG_DUTY_LIM: duty_lim_q <= wdata[DUTY_W-1:0];
					REG_REVERSE:  reverse_q  <= wdata[0];
					REG_MIN_GAP:  min_gap_q  <= wdata[TIME_W-1:0];
					REG_MAX_GAP:  max_gap_q  <= wdata[TIME_W-1:0];
					REG_INV_LIM:  inv_lim_q  <= wdata[STREAK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign cfg.enable     = enable_q;
	assign cfg.duty       = duty_q;
	assign cfg.duty_limit = duty_lim_q;
	assign cfg.reverse    = reverse_q;
	assign cfg.max_gap    = max_gap_q;
	assign cfg.min_eff    = min_eff_q;
	assign cfg.inv_limit  = inv_lim_q;

endmodule

>>> hdl/hssc_track.sv
// ----------------------------------------------------------------------------
// hssc_track
// Run/transition/edge-timing state and phase selection for one hall sample.
// ----------------------------------------------------------------------------
module hssc_track import hssc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  logic [HALL_W-1:0] hall,
	input  logic [TIME_W-1:0] stamp,
	input  cfg_t              cfg,
	output stage_t            res
);

	logic [HALL_W-1:0]   stored_q;
	logic                run_q;
	logic [STREAK_W-1:0] streak_q;
	logic [31:0]         count_q;
	logic [TIME_W-1:0]   base_q;
	logic                base_ok_q;
	logic [31:0]         period_q;
	logic [1:0]          sign_q;

	logic [HALL_W-1:0]   stored_d;
	logic                run_d;
	logic [STREAK_W-1:0] streak_d;
	logic [31:0]         count_d;
	logic [TIME_W-1:0]   base_d;
	logic                base_ok_d;
	logic [31:0]         period_d;
	logic [1:0]          sign_d;

	logic                hall_ok;
	logic                stored_ok;
	logic [STREAK_W-1:0] streak_inc;
	logic [3:0]          ring_diff;
	logic [2:0]          ring_step;
	logic [1:0]          dir;
	logic [TIME_W-1:0]   dt;
	logic [DUTY_W-1:0]   duty_sat;

	always_comb begin
		hall_ok    = hall != HALL_ALL_LOW && hall != HALL_ALL_HIGH;
		stored_ok  = stored_q != HALL_ALL_LOW && stored_q != HALL_ALL_HIGH;
		streak_inc = streak_q + STREAK_W'(1);
		ring_diff  = 4'(RING_POS[hall]) + 4'd6 - 4'(RING_POS[stored_q]);
		ring_step  = (ring_diff >= 4'd6) ? 3'(ring_diff - 4'd6) : ring_diff[2:0];
		// one step round the ring gives the direction; a jump reuses the last one, or forward if there is none yet
		if (ring_step == 3'd1) begin
			dir = DIR_FWD;
		end else if (ring_step == 3'd5) begin
			dir = DIR_REV;
		end else if (sign_q != DIR_NONE) begin
			dir = sign_q;
		end else begin
			dir = DIR_FWD;
		end
		dt = stamp - base_q;

		stored_d  = stored_q;
		run_d     = run_q;
		streak_d  = streak_q;
		count_d   = count_q;
		base_d    = base_q;
		base_ok_d = base_ok_q;
		period_d  = period_q;
		sign_d    = sign_q;

		if (cfg.enable) begin
			if (!hall_ok) begin
				if (run_q) begin
					if (streak_inc >= cfg.inv_limit) begin
						run_d     = 1'b0;
						base_ok_d = 1'b0;
						stored_d  = hall;
						streak_d  = '0;
					end else begin
						streak_d = streak_inc;
					end
				end else begin
					stored_d = hall;
					streak_d = '0;
				end
			end else begin
				streak_d = '0;
				if (!(hall == stored_q && run_q)) begin
					if (run_q && stored_ok && cfg.max_gap != '0) begin
						if (!base_ok_q) begin
							base_d    = stamp;
							base_ok_d = 1'b1;
						end else if (dt >= cfg.min_eff && dt <= cfg.max_gap) begin
							period_d = dt;
							sign_d   = dir;
							base_d   = stamp;
						end else if (dt > cfg.max_gap) begin
							base_d = stamp;
						end
					end
					stored_d = hall;
					run_d    = 1'b1;
					count_d  = count_q + 32'd1;
				end
			end
		end

		duty_sat = (cfg.duty > cfg.duty_limit) ? cfg.duty_limit : cfg.duty;

		res.drive_on         = cfg.enable && hall_ok && cfg.duty != '0;
		res.high_phase       = cfg.reverse ? FWD_LO[hall] : FWD_HI[hall];
		res.low_phase        = cfg.reverse ? FWD_HI[hall] : FWD_LO[hall];
		res.scaled           = SCALED_W'(duty_sat) * PERIOD_SC + ROUND_HALF;
		res.is_running       = run_d;
		res.transition_total = count_d;
		res.edge_period      = period_d;
		res.edge_direction   = sign_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q  <= '0;
			run_q     <= 1'b0;
			streak_q  <= '0;
			count_q   <= '0;
			base_q    <= '0;
			base_ok_q <= 1'b0;
			period_q  <= '0;
			sign_q    <= DIR_NONE;
		end else if (upd) begin
			stored_q  <= stored_d;
			run_q     <= run_d;
			streak_q  <= streak_d;
			count_q   <= count_d;
			base_q    <= base_d;
			base_ok_q <= base_ok_d;
			period_q  <= period_d;
			sign_q    <= sign_d;
		end
	end

endmodule

>>> hdl/hssc_scale.sv
// ----------------------------------------------------------------------------
// hssc_scale
// Scales the rounded duty product to nanoseconds and forms the bridge drive.
// ----------------------------------------------------------------------------
module hssc_scale import hssc_pkg::*; (
	input  stage_t  stg,
	output result_t res
);

	logic [SCALED_W+RECIP_W-1:0] prod;
	logic [QUOT_W-1:0]           quot;
	logic [QUOT_W-1:0]           pulse;
	logic [2:0]                  hi_mask;
	logic [2:0]                  lo_mask;

	always_comb begin
		// divide by 1000 through the reciprocal
		prod  = (SCALED_W+RECIP_W)'(stg.scaled) * (SCALED_W+RECIP_W)'(RECIP_MUL[RECIP_W-1:0]);
		quot  = prod[RECIP_SHIFT +: QUOT_W];
		pulse = (quot > PERIOD_Q) ? PERIOD_Q : quot;

		hi_mask = 3'(4'b0001 << stg.high_phase);
		lo_mask = 3'(4'b0001 << stg.low_phase);

		if (stg.drive_on) begin
			res.high_phase   = stg.high_phase;
			res.low_phase    = stg.low_phase;
			res.pulse_width  = pulse[PULSE_W-1:0];
			res.phase_enable = hi_mask | lo_mask;
		end else begin
			res.high_phase   = NO_PHASE;
			res.low_phase    = NO_PHASE;
			res.pulse_width  = '0;
			res.phase_enable = '0;
		end
		res.is_running       = stg.is_running;
		res.transition_total = stg.transition_total;
		res.edge_period      = stg.edge_period;
		res.edge_direction   = stg.edge_direction;
	end

endmodule

>>> hdl/hall_six_step_commutator.sv
// ----------------------------------------------------------------------------
// hall_six_step_commutator
// Six-step BLDC commutation from hall samples, with edge timing and run state.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   40     hall_code, sample_time
// m_axis    out  96     phase select, pulse, enables, run status, edge timing
// cfg       in   3/32   register index, write data
//
// Three register stages (input, scale, output): a result passes through them in
// order and then stays on m_axis until taken; one transaction is taken every cycle
// unless the output stalls. The edge
// timing state updates as a sample leaves the input stage; the reciprocal
// multiply for the pulse sits in the second stage. Stages close up when the
// output stalls, so up to three transactions are held before s_axis_tready
// falls. Reset clears all valid bits and state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hall_six_step_commutator import hssc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [39:0]           s_axis_tdata,   // hall_code[2:0], sample_time[34:3]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [95:0]           m_axis_tdata,   // high_phase[1:0], low_phase[3:2],
	                                              // pulse_width[19:4], phase_enable[22:20],
	                                              // is_running[23], transition_total[55:24],
	                                              // edge_period[87:56], edge_direction[89:88]
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg;
	stage_t  trk;
	result_t scl;

	logic              v_s1;
	logic [HALL_W-1:0] hall_s1;
	logic [TIME_W-1:0] time_s1;
	logic              v_s2;
	stage_t            stg_s2;
	logic              out_v_q;
	result_t           out_q;

	logic adv_s1;
	logic adv_s2;

	assign adv_s2        = !out_v_q || m_axis_tready;
	assign adv_s1        = !v_s2 || adv_s2;
	assign s_axis_tready = !v_s1 || adv_s1;

	hssc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	hssc_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (v_s1 && adv_s1),
		.hall   (hall_s1),
		.stamp  (time_s1),
		.cfg    (cfg),
		.res    (trk)
	);

	hssc_scale u_scale (
		.stg (stg_s2),
		.res (scl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				v_s2 <= v_s1;
			end
			if (adv_s2) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			hall_s1 <= s_axis_tdata[2:0];
			time_s1 <= s_axis_tdata[34:3];
		end
		if (v_s1 && adv_s1) begin
			stg_s2 <= trk;
		end
		if (v_s2 && adv_s2) begin
			out_q <= scl;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {6'b0, out_q.edge_direction, out_q.edge_period,
		out_q.transition_total, out_q.is_running, out_q.phase_enable,
		out_q.pulse_width, out_q.low_phase, out_q.high_phase};

endmodule
